// ----- design/x11smf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// X11 stream framer package
// Message kinds, framing lengths and the result bundle that the client and
// server trackers hand to the top level.
// ----------------------------------------------------------------------------
package x11smf_pkg;

    typedef enum logic [2:0] {
        KIND_SETUP       = 3'd0,
        KIND_REQUEST     = 3'd1,
        KIND_SETUP_REPLY = 3'd2,
        KIND_ERROR       = 3'd3,
        KIND_REPLY       = 3'd4,
        KIND_EVENT       = 3'd5
    } kind_t;

    // First byte of the client set-up that selects little-endian lengths.
    localparam logic [7:0]  LITTLE_MARK       = 8'h6C;

    localparam logic [7:0]  PACKET_TYPE_ERROR = 8'd0;
    localparam logic [7:0]  PACKET_TYPE_REPLY = 8'd1;

    localparam logic [17:0] CLIENT_SETUP_LEN  = 18'd12;
    localparam logic [17:0] CLIENT_REQ_MIN    = 18'd4;
    localparam logic [34:0] SERVER_SETUP_LEN  = 35'd8;
    localparam logic [34:0] SERVER_PACKET_LEN = 35'd32;

    typedef struct packed {
        kind_t kind;
        logic  first;
        logic  last;
        logic  fault;
    } frame_res_t;

endpackage
`default_nettype wire

// ----- design/x11smf_client.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// X11 framer, client-to-server tracker
// Counts the bytes of the set-up message and of each request, picks up the
// length fields and owns the byte order chosen by the first set-up byte.
// ----------------------------------------------------------------------------
module x11smf_client (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    output x11smf_pkg::frame_res_t     res,
    output logic                       order_little
);

    logic        phase_reg, phase_next;
    logic [17:0] count_reg, count_next;
    logic [17:0] total_reg, total_next;
    logic [7:0]  stash_reg, stash_next;
    logic        order_reg, order_next;

    logic [15:0] join16;
    logic [16:0] padded_sum;
    logic [17:0] pad_len;
    logic [17:0] total_eff;
    logic [17:0] count_inc;
    logic        fault;
    logic        last;

    assign join16     = order_reg ? {data_byte, stash_reg} : {stash_reg, data_byte};
    assign padded_sum = {1'b0, join16} + 17'd3;
    assign pad_len    = {1'b0, padded_sum[16:2], 2'b00};
    assign count_inc  = count_reg + 18'd1;

    always_comb
    begin
        stash_next = stash_reg;
        order_next = order_reg;
        total_eff  = total_reg;
        fault      = 1'b0;
        if (!phase_reg)
        begin
            if (count_reg == 18'd0)
            begin
                order_next = (data_byte == x11smf_pkg::LITTLE_MARK);
            end
            // Name and data lengths sit at bytes 6-7 and 8-9 of the header.
            if (count_reg == 18'd6 || count_reg == 18'd8)
            begin
                stash_next = data_byte;
            end
            if (count_reg == 18'd7 || count_reg == 18'd9)
            begin
                total_eff = total_reg + pad_len;
            end
        end
        else
        begin
            if (count_reg == 18'd2)
            begin
                stash_next = data_byte;
            end
            if (count_reg == 18'd3)
            begin
                if (join16 == 16'd0)
                begin
                    fault     = 1'b1;
                    total_eff = x11smf_pkg::CLIENT_REQ_MIN;
                end
                else
                begin
                    total_eff = {join16, 2'b00};
                end
            end
        end

        last = (count_inc == total_eff);
        if (last)
        begin
            phase_next = 1'b1;
            count_next = 18'd0;
            total_next = x11smf_pkg::CLIENT_REQ_MIN;
            stash_next = 8'd0;
        end
        else
        begin
            phase_next = phase_reg;
            count_next = count_inc;
            total_next = total_eff;
        end
    end

    always_comb
    begin
        res.kind  = phase_reg ? x11smf_pkg::KIND_REQUEST : x11smf_pkg::KIND_SETUP;
        res.first = (count_reg == 18'd0);
        res.last  = last;
        res.fault = fault;
    end

    assign order_little = order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            count_reg <= 18'd0;
            total_reg <= x11smf_pkg::CLIENT_SETUP_LEN;
            stash_reg <= 8'd0;
            order_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            total_reg <= total_next;
            stash_reg <= stash_next;
            order_reg <= order_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/x11smf_server.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// X11 framer, server-to-client tracker
// Frames the set-up reply and then 32-byte packets, extending replies by
// four times their 32-bit length field.
// ----------------------------------------------------------------------------
module x11smf_server (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  order_little,
    output x11smf_pkg::frame_res_t     res
);

    logic              phase_reg, phase_next;
    logic [34:0]       count_reg, count_next;
    logic [34:0]       total_reg, total_next;
    logic [23:0]       stash_reg, stash_next;
    x11smf_pkg::kind_t kind_reg, kind_eff;

    logic [15:0] join16;
    logic [31:0] join32;
    logic [34:0] total_eff;
    logic [34:0] count_inc;
    logic        last;

    assign join16    = order_little ? {data_byte, stash_reg[7:0]}
                                    : {stash_reg[7:0], data_byte};
    assign join32    = order_little ? {data_byte, stash_reg[7:0], stash_reg[15:8],
                                       stash_reg[23:16]}
                                    : {stash_reg, data_byte};
    assign count_inc = count_reg + 35'd1;

    always_comb
    begin
        stash_next = stash_reg;
        total_eff  = total_reg;
        kind_eff   = kind_reg;
        if (!phase_reg)
        begin
            kind_eff = x11smf_pkg::KIND_SETUP_REPLY;
            if (count_reg == 35'd6)
            begin
                stash_next = {16'd0, data_byte};
            end
            if (count_reg == 35'd7)
            begin
                total_eff = x11smf_pkg::SERVER_SETUP_LEN + {17'd0, join16, 2'b00};
            end
        end
        else
        begin
            if (count_reg == 35'd0)
            begin
                if (data_byte == x11smf_pkg::PACKET_TYPE_ERROR)
                begin
                    kind_eff = x11smf_pkg::KIND_ERROR;
                end
                else if (data_byte == x11smf_pkg::PACKET_TYPE_REPLY)
                begin
                    kind_eff = x11smf_pkg::KIND_REPLY;
                end
                else
                begin
                    kind_eff = x11smf_pkg::KIND_EVENT;
                end
            end
            if (kind_eff == x11smf_pkg::KIND_REPLY)
            begin
                // The reply length occupies bytes 4 through 7.
                if (count_reg >= 35'd4 && count_reg <= 35'd6)
                begin
                    stash_next = {stash_reg[15:0], data_byte};
                end
                if (count_reg == 35'd7)
                begin
                    total_eff = x11smf_pkg::SERVER_PACKET_LEN + {1'b0, join32, 2'b00};
                end
            end
        end

        last = (count_inc == total_eff);
        if (last)
        begin
            phase_next = 1'b1;
            count_next = 35'd0;
            total_next = x11smf_pkg::SERVER_PACKET_LEN;
            stash_next = 24'd0;
        end
        else
        begin
            phase_next = phase_reg;
            count_next = count_inc;
            total_next = total_eff;
        end
    end

    always_comb
    begin
        res.kind  = kind_eff;
        res.first = (count_reg == 35'd0);
        res.last  = last;
        res.fault = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            count_reg <= 35'd0;
            total_reg <= x11smf_pkg::SERVER_SETUP_LEN;
            stash_reg <= 24'd0;
            kind_reg  <= x11smf_pkg::KIND_SETUP_REPLY;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            total_reg <= total_next;
            stash_reg <= stash_next;
            kind_reg  <= kind_eff;
        end
    end

endmodule
`default_nettype wire

// ----- design/x11_stream_message_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// X11 stream message framer
// Passes the bytes of an X11 connection through and marks where set-up
// messages, requests, set-up replies, errors, replies and events begin and
// end, for both directions of the connection.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    direction, data_byte
//   output    out_valid/out_ready  out_byte, out_direction, message_kind,
//                                  first_of_message, last_of_message,
//                                  length_fault
//
// One transaction is accepted per cycle while the output side keeps taking
// results; a byte passes an input register and then a result register.
// Between them sit a length addition, a counter increment and a compare per
// direction (35 bits on the server side), which set the clock period.
// A stalled output holds the result register; the input register takes one
// more transaction before in_ready drops. Reset restarts both set-up messages.
//
module x11_stream_message_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        direction,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_direction,
    output logic [2:0]       message_kind,
    output logic             first_of_message,
    output logic             last_of_message,
    output logic             length_fault
);

    // Input register stage.
    logic        s1_valid_reg;
    logic        s1_dir_reg;
    logic [7:0]  s1_byte_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_dir_reg;
    x11smf_pkg::frame_res_t out_res_reg;

    logic                   s1_advance;
    logic                   order_little;
    x11smf_pkg::frame_res_t client_res;
    x11smf_pkg::frame_res_t server_res;
    x11smf_pkg::frame_res_t sel_res;

    // The byte in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle; the trackers update their
    // state at that same edge, so state follows stream order exactly.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    x11smf_client u_client (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_advance && !s1_dir_reg),
        .data_byte    (s1_byte_reg),
        .res          (client_res),
        .order_little (order_little)
    );

    // The server side reads the byte order that the client set-up chose.
    x11smf_server u_server (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_advance && s1_dir_reg),
        .data_byte    (s1_byte_reg),
        .order_little (order_little),
        .res          (server_res)
    );

    assign sel_res = s1_dir_reg ? server_res : client_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_dir_reg  <= direction;
            s1_byte_reg <= data_byte;
        end
        if (s1_advance)
        begin
            out_byte_reg <= s1_byte_reg;
            out_dir_reg  <= s1_dir_reg;
            out_res_reg  <= sel_res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_byte         = out_byte_reg;
    assign out_direction    = out_dir_reg;
    assign message_kind     = out_res_reg.kind;
    assign first_of_message = out_res_reg.first;
    assign last_of_message  = out_res_reg.last;
    assign length_fault     = out_res_reg.fault;

    // A length fault is only ever raised on the closing byte of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && length_fault) |->
            (last_of_message && !out_direction
             && message_kind == x11smf_pkg::KIND_REQUEST))
        else $error("length fault outside the closing byte of a request");

    // Client bytes carry only client message kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_direction) |->
            (message_kind == x11smf_pkg::KIND_SETUP
             || message_kind == x11smf_pkg::KIND_REQUEST))
        else $error("client byte tagged with a server message kind");

    // Server bytes never carry client message kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_direction) |->
            (message_kind != x11smf_pkg::KIND_SETUP
             && message_kind != x11smf_pkg::KIND_REQUEST))
        else $error("server byte tagged with a client message kind");

    // A byte that leaves the input register always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid)
        else $error("advanced transaction did not reach the output");

endmodule
`default_nettype wire

// ----- bench/x11_stream_message_framer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// X11 stream message framer testbench
// Feeds set-up messages, requests and server packets of both directions of
// an X11 connection through the framer. A local copy of the framing rules
// predicts the kind, boundary and fault marks of every byte, and each
// result transaction is checked against them in order.
// ----------------------------------------------------------------------------
module x11_stream_message_framer_tb;

    // A correct run never goes long without a transaction on either channel:
    // sender gaps and receiver stalls are short, and there is only one long
    // receiver hold-off.
    localparam int WATCHDOG_LIMIT    = 1500;
    localparam int MAX_REPORTS       = 10;
    localparam int HOLD_AFTER        = 120;
    localparam int HOLD_CYCLES       = 90;
    localparam int DRAIN_CYCLES      = 8;
    localparam int WELL_FORMED_BYTES = 340;
    localparam int NOISE_BYTES       = 30;

    // Big-endian mark of the set-up byte-order field ('B').
    localparam logic [7:0] BIG_MARK = 8'h42;

    // One byte as it travels on the link.
    typedef struct packed {
        logic       dir;
        logic [7:0] data;
    } link_byte_t;

    // One byte as it leaves the framer, with its marks.
    typedef struct packed {
        logic [7:0]        data;
        logic              dir;
        x11smf_pkg::kind_t kind;
        logic              first;
        logic              last;
        logic              fault;
    } framed_byte_t;

    // Receiver stall styles; each holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_MOSTLY,
        RX_GATED
    } rx_style_t;

    // Clock, reset and the two channels. Every input starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       direction = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_direction;
    logic [2:0] message_kind;
    logic       first_of_message;
    logic       last_of_message;
    logic       length_fault;

    x11_stream_message_framer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .direction        (direction),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_byte         (out_byte),
        .out_direction    (out_direction),
        .message_kind     (message_kind),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .length_fault     (length_fault)
    );

    // ------------------------------------------------------------------
    // Framing predictor state. Reset is applied once, so the reset values
    // are simply the initial values.
    // ------------------------------------------------------------------
    logic              cl_in_requests = 1'b0;
    logic [17:0]       cl_count       = 18'd0;
    logic [17:0]       cl_total       = x11smf_pkg::CLIENT_SETUP_LEN;
    logic [7:0]        cl_held        = 8'h00;
    logic              sv_in_packets  = 1'b0;
    logic [34:0]       sv_count       = 35'd0;
    logic [34:0]       sv_total       = x11smf_pkg::SERVER_SETUP_LEN;
    logic [23:0]       sv_held        = 24'h0;
    x11smf_pkg::kind_t sv_kind        = x11smf_pkg::KIND_SETUP_REPLY;
    logic              order_le       = 1'b0;

    // Stimulus and scoreboard storage.
    logic [7:0]   client_msg_q[$];
    logic [7:0]   server_msg_q[$];
    link_byte_t   byte_feed_q[$];
    framed_byte_t framed_q[$];
    logic         gen_le = 1'b0;

    // Bookkeeping shared by the processes.
    logic in_took      = 1'b0;
    int   total_items  = 0;
    int   bytes_taken  = 0;
    int   bytes_per_dir[2];
    int   results_seen = 0;
    int   mismatches   = 0;
    int   closed_by_kind[6];
    int   faults_flagged = 0;
    int   idle_cycles  = 0;

    // Sender and receiver pacing.
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        hold_left   = 0;
    logic      hold_done   = 1'b0;
    int        style_left  = 0;
    int        rx_tick     = 0;
    rx_style_t rx_style    = RX_STEADY;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Joins a held length byte with the current one in the negotiated order.
    function automatic logic [15:0] join_len16(input logic [7:0] held, input logic [7:0] b);
        return order_le ? {b, held} : {held, b};
    endfunction

    // Advances the framing state by one byte and returns the marks the
    // framer must attach to it.
    function automatic framed_byte_t frame_byte(input logic dir, input logic [7:0] b);
        framed_byte_t m;
        logic [15:0]  len16;
        logic [31:0]  len32;
        logic [17:0]  cl_next;
        logic [34:0]  sv_next;
        m.data  = b;
        m.dir   = dir;
        m.fault = 1'b0;
        if (!dir)
        begin
            m.kind  = cl_in_requests ? x11smf_pkg::KIND_REQUEST : x11smf_pkg::KIND_SETUP;
            m.first = (cl_count == 18'd0);
            if (!cl_in_requests)
            begin
                // The byte-order byte takes effect for the set-up lengths at once.
                if (cl_count == 18'd0)
                    order_le = (b == x11smf_pkg::LITTLE_MARK);
                if (cl_count == 18'd6 || cl_count == 18'd8)
                    cl_held = b;
                // Name and data lengths are each padded up to a multiple of four.
                if (cl_count == 18'd7 || cl_count == 18'd9)
                begin
                    len16    = join_len16(cl_held, b);
                    cl_total = cl_total + (({2'b00, len16} + 18'd3) & ~18'd3);
                end
            end
            else
            begin
                if (cl_count == 18'd2)
                    cl_held = b;
                if (cl_count == 18'd3)
                begin
                    len16 = join_len16(cl_held, b);
                    // A zero length is flagged and framed as a minimal request.
                    if (len16 == 16'd0)
                    begin
                        m.fault  = 1'b1;
                        cl_total = x11smf_pkg::CLIENT_REQ_MIN;
                    end
                    else
                        cl_total = {len16, 2'b00};
                end
            end
            cl_next = cl_count + 18'd1;
            m.last  = (cl_next == cl_total);
            if (m.last)
            begin
                cl_in_requests = 1'b1;
                cl_count       = 18'd0;
                cl_total       = x11smf_pkg::CLIENT_REQ_MIN;
                cl_held        = 8'h00;
            end
            else
                cl_count = cl_next;
        end
        else
        begin
            if (!sv_in_packets)
            begin
                if (sv_count == 35'd6)
                    sv_held = {16'h0, b};
                if (sv_count == 35'd7)
                begin
                    len16    = join_len16(sv_held[7:0], b);
                    sv_total = x11smf_pkg::SERVER_SETUP_LEN + {17'd0, len16, 2'b00};
                end
                sv_kind = x11smf_pkg::KIND_SETUP_REPLY;
            end
            else
            begin
                if (sv_count == 35'd0)
                begin
                    if (b == x11smf_pkg::PACKET_TYPE_ERROR)
                        sv_kind = x11smf_pkg::KIND_ERROR;
                    else if (b == x11smf_pkg::PACKET_TYPE_REPLY)
                        sv_kind = x11smf_pkg::KIND_REPLY;
                    else
                        sv_kind = x11smf_pkg::KIND_EVENT;
                end
                if (sv_kind == x11smf_pkg::KIND_REPLY)
                begin
                    if (sv_count >= 35'd4 && sv_count <= 35'd6)
                        sv_held = {sv_held[15:0], b};
                    // The reply length keeps all 32 bits.
                    if (sv_count == 35'd7)
                    begin
                        len32 = order_le ? {b, sv_held[7:0], sv_held[15:8], sv_held[23:16]}
                                         : {sv_held, b};
                        sv_total = x11smf_pkg::SERVER_PACKET_LEN + {1'b0, len32, 2'b00};
                    end
                end
            end
            m.kind  = sv_kind;
            m.first = (sv_count == 35'd0);
            sv_next = sv_count + 35'd1;
            m.last  = (sv_next == sv_total);
            if (m.last)
            begin
                sv_in_packets = 1'b1;
                sv_count      = 35'd0;
                sv_total      = x11smf_pkg::SERVER_PACKET_LEN;
                sv_held       = 24'h0;
            end
            else
                sv_count = sv_next;
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Message builders
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_msg_byte(input logic dir, input logic [7:0] b);
        if (dir)
            server_msg_q.push_back(b);
        else
            client_msg_q.push_back(b);
    endtask

    // Writes a 16-bit length in the byte order that the stream uses.
    task automatic put_len16(input logic dir, input logic [15:0] v);
        put_msg_byte(dir, gen_le ? v[7:0] : v[15:8]);
        put_msg_byte(dir, gen_le ? v[15:8] : v[7:0]);
    endtask

    // Moves the next byte of one direction's message onto the link.
    task automatic move_msg_byte(input logic dir);
        link_byte_t lb;
        lb.dir  = dir;
        lb.data = dir ? server_msg_q.pop_front() : client_msg_q.pop_front();
        byte_feed_q.push_back(lb);
    endtask

    task automatic append_request(input logic [15:0] words);
        int total;
        int i;
        total = (words == 16'd0) ? 4 : 4 * int'(words);
        put_msg_byte(1'b0, rand_byte());
        put_msg_byte(1'b0, rand_byte());
        put_len16(1'b0, words);
        for (i = 4; i < total; i++)
            put_msg_byte(1'b0, rand_byte());
    endtask

    task automatic append_packet(input logic [7:0] ptype, input logic [31:0] words);
        int i;
        int extra;
        put_msg_byte(1'b1, ptype);
        for (i = 1; i < 4; i++)
            put_msg_byte(1'b1, rand_byte());
        for (i = 0; i < 4; i++)
            if (ptype == x11smf_pkg::PACKET_TYPE_REPLY)
                put_msg_byte(1'b1, gen_le ? words[8*i +: 8] : words[8*(3-i) +: 8]);
            else
                put_msg_byte(1'b1, rand_byte());
        extra = (ptype == x11smf_pkg::PACKET_TYPE_REPLY) ? 4 * int'(words) : 0;
        for (i = 8; i < 32 + extra; i++)
            put_msg_byte(1'b1, rand_byte());
    endtask

    task automatic note_fault(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endtask

    function automatic string describe(input framed_byte_t m);
        return $sformatf("byte %02h dir %0d kind %0d first %0d last %0d fault %0d",
                         m.data, m.dir, m.kind, m.first, m.last, m.fault);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver. Works on the falling edge. A byte stays on the input with
    // valid high until the rising edge that accepts it; only then does the
    // next byte of the burst, or a gap, follow.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_p
        link_byte_t nxt;
        int         r;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_feed_q.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                nxt = byte_feed_q.pop_front();
                in_valid  <= 1'b1;
                direction <= nxt.dir;
                data_byte <= nxt.data;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    // Mostly short bursts with gaps; now and then a long
                    // stretch at full rate.
                    r = $urandom_range(0, 9);
                    if (r < 2)
                    begin
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Changes style after each random stretch. Once enough results
    // have arrived it holds ready low for a long stretch while the sender
    // keeps offering, so the framer fills up and drops in_ready.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : receive_p
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_tick++;
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (style_left == 0)
            begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 80);
            end
            else
                style_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (rx_style)
                    RX_STEADY: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                    default:   out_ready <= ((rx_tick % 7) < 4);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor and scoreboard. Both channels are sampled on the rising edge.
    // An accepted input byte is run through the predictor at once; an
    // accepted result must match the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_p
        framed_byte_t got;
        framed_byte_t want;
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                framed_q.push_back(frame_byte(direction, data_byte));
                bytes_per_dir[direction]++;
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                got.data  = out_byte;
                got.dir   = out_direction;
                got.kind  = x11smf_pkg::kind_t'(message_kind);
                got.first = first_of_message;
                got.last  = last_of_message;
                got.fault = length_fault;
                results_seen++;
                if (framed_q.size() == 0)
                    note_fault($sformatf("unexpected result: %s", describe(got)));
                else
                begin
                    want = framed_q.pop_front();
                    if (got !== want)
                        note_fault($sformatf("result %0d mismatch: expected %s, got %s",
                                             results_seen, describe(want), describe(got)));
                    else
                    begin
                        if (want.last)
                            closed_by_kind[want.kind]++;
                        if (want.fault)
                            faults_flagged++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles in a row with no transaction on either channel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog_p
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, framed_q.size());
            $display("** x11_stream_message_framer: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus_p
        int         r;
        int         i;
        int         n_name;
        int         n_data;
        int         packets_made;
        logic [7:0] order_byte;
        logic [15:0] words;
        link_byte_t lb;

        // Directed opening. The server set-up reply goes first, before the
        // client has chosen a byte order, so its length is read big endian.
        put_msg_byte(1'b1, 8'h01);
        put_msg_byte(1'b1, 8'hFF);
        put_len16(1'b1, 16'd11);
        put_len16(1'b1, 16'd0);
        put_len16(1'b1, 16'd1);
        for (i = 0; i < 4; i++)
            put_msg_byte(1'b1, rand_byte());
        while (server_msg_q.size() != 0)
            move_msg_byte(1'b1);

        // Client set-up: little-endian mark, the big-endian mark, or any
        // other value, which also means big endian.
        r = $urandom_range(0, 3);
        case (r)
            0, 1:    order_byte = x11smf_pkg::LITTLE_MARK;
            2:       order_byte = BIG_MARK;
            default:
            begin
                order_byte = rand_byte();
                if (order_byte == x11smf_pkg::LITTLE_MARK)
                    order_byte = 8'h00;
            end
        endcase
        gen_le = (order_byte == x11smf_pkg::LITTLE_MARK);
        n_name = $urandom_range(0, 6);
        n_data = $urandom_range(0, 6);
        put_msg_byte(1'b0, order_byte);
        put_msg_byte(1'b0, 8'h00);
        put_len16(1'b0, 16'd11);
        put_len16(1'b0, 16'd0);
        put_len16(1'b0, 16'(n_name));
        put_len16(1'b0, 16'(n_data));
        put_msg_byte(1'b0, 8'hFF);
        put_msg_byte(1'b0, 8'hFF);
        for (i = 0; i < ((n_name + 3) & ~3) + ((n_data + 3) & ~3); i++)
            put_msg_byte(1'b0, rand_byte());
        // A zero-length request, then a one-word request.
        append_request(16'd0);
        append_request(16'd1);
        while (client_msg_q.size() != 0)
            move_msg_byte(1'b0);

        // Random part: well-formed traffic in both directions, interleaved
        // byte by byte. The first server packets are a zero-length reply,
        // an error and an event; after that the mix is random.
        packets_made = 0;
        while (byte_feed_q.size() < WELL_FORMED_BYTES)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                if (server_msg_q.size() == 0)
                begin
                    r = $urandom_range(0, 9);
                    if (packets_made == 0)
                        append_packet(x11smf_pkg::PACKET_TYPE_REPLY, 32'd0);
                    else if (packets_made == 1)
                        append_packet(x11smf_pkg::PACKET_TYPE_ERROR, 32'd0);
                    else if (packets_made == 2)
                        append_packet(8'hFF, 32'd0);
                    else if (r < 2)
                        append_packet(x11smf_pkg::PACKET_TYPE_ERROR, 32'd0);
                    else if (r < 6)
                        append_packet(x11smf_pkg::PACKET_TYPE_REPLY,
                                      ($urandom_range(0, 3) == 0) ? 32'd0
                                                                  : 32'($urandom_range(1, 3)));
                    else
                        append_packet(8'($urandom_range(2, 255)), 32'd0);
                    packets_made++;
                end
                move_msg_byte(1'b1);
            end
            else
            begin
                if (client_msg_q.size() == 0)
                begin
                    r = $urandom_range(0, 9);
                    words = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : 16'($urandom_range(2, 6));
                    append_request(words);
                end
                move_msg_byte(1'b0);
            end
        end

        // Finish the server packet in flight, then open a reply whose length
        // has every bit set: it must not close within the rest of the run.
        while (server_msg_q.size() != 0)
            move_msg_byte(1'b1);
        put_msg_byte(1'b1, x11smf_pkg::PACKET_TYPE_REPLY);
        for (i = 1; i < 4; i++)
            put_msg_byte(1'b1, rand_byte());
        for (i = 4; i < 8; i++)
            put_msg_byte(1'b1, 8'hFF);
        for (i = 8; i < 14; i++)
            put_msg_byte(1'b1, rand_byte());
        while (server_msg_q.size() != 0)
            move_msg_byte(1'b1);

        // Noise: random bytes in random directions, which also breaks off
        // whatever client request was half sent.
        for (i = 0; i < NOISE_BYTES; i++)
        begin
            lb.dir  = 1'($urandom_range(0, 1));
            lb.data = rand_byte();
            byte_feed_q.push_back(lb);
        end
        total_items = byte_feed_q.size();

        // Reset is held from the start and released on a falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be accepted and every result to arrive,
        // then keep watching a little longer to catch any stray result.
        while (bytes_taken < total_items || framed_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Framed %0d client and %0d server bytes; %0d zero-length requests flagged.",
                 bytes_per_dir[0], bytes_per_dir[1], faults_flagged);
        $display("Closed %0d setup, %0d req, %0d setup reply, %0d err, %0d reply, %0d event.",
                 closed_by_kind[x11smf_pkg::KIND_SETUP],
                 closed_by_kind[x11smf_pkg::KIND_REQUEST],
                 closed_by_kind[x11smf_pkg::KIND_SETUP_REPLY],
                 closed_by_kind[x11smf_pkg::KIND_ERROR],
                 closed_by_kind[x11smf_pkg::KIND_REPLY],
                 closed_by_kind[x11smf_pkg::KIND_EVENT]);
        if (mismatches == 0 && framed_q.size() == 0)
            $display("** x11_stream_message_framer: PASSED **");
        else
            $display("** x11_stream_message_framer: FAILED **");
        $finish;
    end

endmodule
